// ===== sv/bang_bang_trajectory_generator_core_macros.svh =====
// Assertion helpers for the trajectory generator RTL.
// Every check runs on the rising edge of clk_i and is off while rst_ni is low.
`ifndef BANG_BANG_TRAJECTORY_GENERATOR_CORE_MACROS_SVH
`define BANG_BANG_TRAJECTORY_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBTG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBTG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bbtg_pkg.sv =====
package bbtg_pkg;

  // Field and register widths.
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 27;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 4;

  // Datapath widths. The half-move offset u never exceeds half the duration.
  localparam int MAG_W  = 32;
  localparam int U_W    = DUR_W - 1;
  localparam int VEL_W  = 20;
  localparam int W_W    = 2 * U_W;
  localparam int HALF_W = W_W / 2;
  localparam int PP_W   = MAG_W + HALF_W;
  localparam int PROD_W = MAG_W + W_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = 2 * DUR_W;
  localparam int QUO_W  = DATA_W;

  // Three axes, three quantities per axis.
  localparam int AXES  = 3;
  localparam int KINDS = 3;
  localparam int K_POS = 0;
  localparam int K_VEL = 1;
  localparam int K_ACC = 2;

  // Pipeline depth: the divider holds one entry stage plus one stage per quotient bit.
  localparam int DIV_LAT = QUO_W + 1;
  localparam int SIDE_N  = 4 + DIV_LAT;
  localparam int LATENCY = SIDE_N + 3;

  // Scale factors between ticks and seconds.
  localparam logic [VEL_W-1:0] VEL_SCALE = 20'd1000000;
  localparam logic [W_W-1:0]   ACC_SCALE = 52'd1000000000000;
  localparam logic [DUR_W-1:0] DUR_RESET = 27'd1000000;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIME = 4'd0,
    REG_DURATION   = 4'd1,
    REG_START_X    = 4'd2,
    REG_START_Y    = 4'd3,
    REG_START_Z    = 4'd4,
    REG_END_X      = 4'd5,
    REG_END_Y      = 4'd6,
    REG_END_Z      = 4'd7
  } bbtg_reg_e;

  // Where the sample time falls relative to the move.
  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_INSIDE = 2'd1,
    PH_AFTER  = 2'd2
  } bbtg_phase_e;

  // Control that travels alongside each item.
  typedef struct packed {
    logic        valid;
    bbtg_phase_e phase;
    logic        first;
  } bbtg_side_t;

  // Signed magnitude to a saturated two's complement word.
  function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic ovf,
                                                input logic [QUO_W-1:0] q);
    logic [DATA_W-1:0] r;
    if (neg) begin
      if (ovf || q[QUO_W-1]) begin
        r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        r = '0 - q;
      end
    end else begin
      if (ovf || q[QUO_W-1]) begin
        r = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        r = q;
      end
    end
    return r;
  endfunction

  // Base position plus or minus an unsigned offset, saturated to 32 bits.
  function automatic logic [DATA_W-1:0] sat_pos(input logic [DATA_W-1:0] base,
                                                input logic [QUO_W-1:0] off,
                                                input logic sub);
    logic [DATA_W+1:0] ext_b;
    logic [DATA_W+1:0] ext_o;
    logic [DATA_W+1:0] sum;
    logic [DATA_W-1:0] r;
    ext_b = {{2{base[DATA_W-1]}}, base};
    ext_o = {2'b00, off};
    sum   = sub ? (ext_b - ext_o) : (ext_b + ext_o);
    if (sum[DATA_W+1] == sum[DATA_W] && sum[DATA_W] == sum[DATA_W-1]) begin
      r = sum[DATA_W-1:0];
    end else if (sum[DATA_W+1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/bbtg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees a nonzero divisor that stays put while items are in flight.
// A quotient of 2^QUO_W or more is flagged on ovf_o and the quotient bits then carry no meaning.
module bbtg_div import bbtg_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] low_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  logic [DEN_W-1:0] num_top;
  logic             num_big;

  // The upper part of the dividend fits the divisor width by construction.
  assign num_top = DEN_W'(num_i >> QUO_W);
  assign num_big = (num_top >= den_i);

  // Entry stage: the upper part is the first partial remainder.
  always_ff @(posedge clk_i) begin
    ovf_q[0] <= num_big;
    rem_q[0] <= num_big ? '0 : num_top;
    low_q[0] <= num_i[QUO_W-1:0];
    quo_q[0] <= '0;
  end

  // Each stage shifts in one dividend bit and subtracts the divisor when it fits.
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    logic [DEN_W:0] cand;
    logic [DEN_W:0] diff;
    logic           fits;

    assign cand = {rem_q[s], low_q[s][QUO_W-1]};
    assign diff = cand - {1'b0, den_i};
    assign fits = (cand >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= fits ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
      low_q[s+1] <= {low_q[s][QUO_W-2:0], 1'b0};
      quo_q[s+1] <= {quo_q[s][QUO_W-2:0], fits};
      ovf_q[s+1] <= ovf_q[s];
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

// ===== sv/bang_bang_trajectory_generator_core.sv =====
// Each accepted sample passes the front stages, the multipliers, the dividers and the output register, in order.
// Throughput: one sample per cycle; busy stays low and a new sample may enter every cycle.
// Most of the depth is the restoring divider behind each of the nine outputs.
// A register write is seen by a sample accepted in the following cycle.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and loads the register
// defaults: start time 0, duration 1000000 ticks, all points 0. Results cannot be stalled.
`include "bang_bang_trajectory_generator_core_macros.svh"

module bang_bang_trajectory_generator_core import bbtg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command channel.
  input  logic                 start,
  output logic                 busy,
  input  logic [TIME_W-1:0]    sample_time_i,
  // Result channel.
  output logic                 result_valid_o,
  output logic [DATA_W-1:0]    pos_x_o,
  output logic [DATA_W-1:0]    pos_y_o,
  output logic [DATA_W-1:0]    pos_z_o,
  output logic [DATA_W-1:0]    vel_x_o,
  output logic [DATA_W-1:0]    vel_y_o,
  output logic [DATA_W-1:0]    vel_z_o,
  output logic [DATA_W-1:0]    acc_x_o,
  output logic [DATA_W-1:0]    acc_y_o,
  output logic [DATA_W-1:0]    acc_z_o,
  // Register write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  // Configuration registers.
  logic [TIME_W-1:0] start_time_q;
  logic [DUR_W-1:0]  duration_q;
  logic [DATA_W-1:0] start_q [AXES];
  logic [DATA_W-1:0] end_q   [AXES];

  // Values derived from the registers.
  logic [DUR_W-1:0]  t_safe;
  logic [DATA_W:0]   diff_d [AXES];
  logic [DEN_W-1:0]  den_q;
  logic [MAG_W-1:0]  mag_q [AXES];
  logic              neg_q [AXES];

  // Front of the pipeline.
  logic              accept;
  logic              v1_q;
  logic [TIME_W-1:0] t1_q;
  logic [TIME_W:0]   end_time;
  logic [TIME_W-1:0] dt_full;
  bbtg_phase_e       phase_d;
  logic              v2_q;
  bbtg_phase_e       phase2_q;
  logic [DUR_W-1:0]  dt2_q;
  logic              first_d;
  logic [DUR_W-1:0]  u_full;
  logic [U_W-1:0]    u3_q;
  logic [W_W-1:0]    u_sq;
  logic [U_W+VEL_W-1:0] u_vel;

  // Side band, one entry per stage from the half decision to the divider output.
  bbtg_side_t        side_q [SIDE_N];
  bbtg_side_t        side_out;

  // Multiplier operands, partial products and full products.
  logic [W_W-1:0]    w_q     [KINDS];
  logic [PP_W-1:0]   pp_lo_q [AXES][KINDS];
  logic [PP_W-1:0]   pp_hi_q [AXES][KINDS];
  logic [PROD_W-1:0] prod_q  [AXES][KINDS];
  logic [NUM_W-1:0]  num     [AXES][KINDS];
  logic [QUO_W-1:0]  quo     [AXES][KINDS];
  logic              ovf     [AXES][KINDS];

  // Result assembly.
  logic              sgn   [AXES];
  logic [QUO_W-1:0]  off   [AXES];
  logic [DATA_W-1:0] pos_d [AXES];
  logic [DATA_W-1:0] vel_d [AXES];
  logic [DATA_W-1:0] acc_d [AXES];
  logic [DATA_W-1:0] pos_q [AXES];
  logic [DATA_W-1:0] vel_q [AXES];
  logic [DATA_W-1:0] acc_q [AXES];
  logic              out_valid_q;

  // Every cycle can take a sample and every register transfer.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      duration_q   <= DUR_RESET;
      for (int a = 0; a < AXES; a++) begin
        start_q[a] <= '0;
        end_q[a]   <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_START_TIME: start_time_q <= cfg_data_i;
        REG_DURATION:   duration_q   <= cfg_data_i[DUR_W-1:0];
        REG_START_X:    start_q[0]   <= cfg_data_i;
        REG_START_Y:    start_q[1]   <= cfg_data_i;
        REG_START_Z:    start_q[2]   <= cfg_data_i;
        REG_END_X:      end_q[0]     <= cfg_data_i;
        REG_END_Y:      end_q[1]     <= cfg_data_i;
        REG_END_Z:      end_q[2]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero duration counts as one tick.
  assign t_safe = (duration_q == '0) ? DUR_W'(1) : duration_q;

  // Per-axis distance as sign and magnitude.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      diff_d[a] = {end_q[a][DATA_W-1], end_q[a]} - {start_q[a][DATA_W-1], start_q[a]};
    end
  end

  // Derived values follow the registers in the next cycle.
  always_ff @(posedge clk_i) begin
    den_q <= DEN_W'(t_safe) * DEN_W'(t_safe);
    for (int a = 0; a < AXES; a++) begin
      neg_q[a] <= diff_d[a][DATA_W];
      mag_q[a] <= diff_d[a][DATA_W] ? MAG_W'('0 - diff_d[a]) : diff_d[a][MAG_W-1:0];
    end
  end

  // Place the sample before, inside or after the move; the end tick is inside.
  assign end_time = {1'b0, start_time_q} + (TIME_W + 1)'(t_safe);
  assign dt_full  = t1_q - start_time_q;

  always_comb begin
    if (t1_q < start_time_q) begin
      phase_d = PH_BEFORE;
    end else if ({1'b0, t1_q} > end_time) begin
      phase_d = PH_AFTER;
    end else begin
      phase_d = PH_INSIDE;
    end
  end

  // Pick the half; the midpoint belongs to the second half.
  assign first_d = ({dt2_q, 1'b0} < {1'b0, t_safe});
  assign u_full  = first_d ? dt2_q : (t_safe - dt2_q);

  // Operands for position, velocity and acceleration.
  assign u_sq  = W_W'(u3_q) * W_W'(u3_q);
  assign u_vel = (U_W + VEL_W)'(u3_q) * (U_W + VEL_W)'(VEL_SCALE);

  // Valid bits of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SIDE_N; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      v1_q      <= accept;
      v2_q      <= v1_q;
      side_q[0] <= '{valid: v2_q, phase: phase2_q, first: first_d};
      for (int i = 1; i < SIDE_N; i++) begin
        side_q[i] <= side_q[i-1];
      end
      out_valid_q <= side_out.valid;
    end
  end

  // Data stages up to the dividers.
  always_ff @(posedge clk_i) begin
    t1_q     <= sample_time_i;
    phase2_q <= phase_d;
    dt2_q    <= dt_full[DUR_W-1:0];
    u3_q     <= u_full[U_W-1:0];
    w_q[K_POS] <= u_sq;
    w_q[K_VEL] <= W_W'(u_vel);
    w_q[K_ACC] <= ACC_SCALE;
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < KINDS; k++) begin
        pp_lo_q[a][k] <= PP_W'(mag_q[a]) * PP_W'(w_q[k][HALF_W-1:0]);
        pp_hi_q[a][k] <= PP_W'(mag_q[a]) * PP_W'(w_q[k][W_W-1:HALF_W]);
        prod_q[a][k]  <= PROD_W'(pp_lo_q[a][k]) + {pp_hi_q[a][k], {HALF_W{1'b0}}};
      end
    end
  end

  // Position takes twice the product, velocity and acceleration four times.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < KINDS; k++) begin
        if (k == K_POS) begin
          num[a][k] = NUM_W'({prod_q[a][k], 1'b0});
        end else begin
          num[a][k] = NUM_W'({prod_q[a][k], 2'b00});
        end
      end
    end
  end

  // One divider per output, all by the squared duration.
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    for (genvar k = 0; k < KINDS; k++) begin : g_kind
      bbtg_div u_div (
        .clk_i (clk_i),
        .num_i (num[a][k]),
        .den_i (den_q),
        .quo_o (quo[a][k]),
        .ovf_o (ovf[a][k])
      );
    end
  end

  assign side_out = side_q[SIDE_N-1];

  // Sign, saturation and the hold values outside the move.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sgn[a] = neg_q[a] ^ ~side_out.first;
      off[a] = ovf[a][K_POS] ? '1 : quo[a][K_POS];
      case (side_out.phase)
        PH_BEFORE: begin
          pos_d[a] = start_q[a];
          vel_d[a] = '0;
          acc_d[a] = '0;
        end
        PH_AFTER: begin
          pos_d[a] = end_q[a];
          vel_d[a] = '0;
          acc_d[a] = '0;
        end
        PH_INSIDE: begin
          pos_d[a] = sat_pos(side_out.first ? start_q[a] : end_q[a], off[a], sgn[a]);
          vel_d[a] = sat_mag(neg_q[a], ovf[a][K_VEL], quo[a][K_VEL]);
          acc_d[a] = sat_mag(sgn[a], ovf[a][K_ACC], quo[a][K_ACC]);
        end
        default: begin
          pos_d[a] = '0;
          vel_d[a] = '0;
          acc_d[a] = '0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AXES; a++) begin
      pos_q[a] <= pos_d[a];
      vel_q[a] <= vel_d[a];
      acc_q[a] <= acc_d[a];
    end
  end

  assign result_valid_o = out_valid_q;
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];
  assign vel_x_o = vel_q[0];
  assign vel_y_o = vel_q[1];
  assign vel_z_o = vel_q[2];
  assign acc_x_o = acc_q[0];
  assign acc_y_o = acc_q[1];
  assign acc_z_o = acc_q[2];

  // Every result transfer belongs to an earlier accepted sample.
  `BBTG_ASSERT_IMP(a_latency, result_valid_o,
      $past(start && !busy, LATENCY), "result without an accepted sample")
  // A sample before the move yields the start point at rest.
  `BBTG_ASSERT_NXT(a_before_hold, side_out.valid && side_out.phase == PH_BEFORE,
      pos_x_o == $past(start_q[0]) && vel_x_o == '0 && acc_x_o == '0,
      "before the move the start point must hold")
  // A sample after the move yields the end point at rest.
  `BBTG_ASSERT_NXT(a_after_hold, side_out.valid && side_out.phase == PH_AFTER,
      pos_y_o == $past(end_q[1]) && pos_z_o == $past(end_q[2]) && vel_z_o == '0 && acc_y_o == '0,
      "after the move the end point must hold")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bbtg_pkg::*;

  localparam int          LIMIT_CYCLES     = 400000;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          TAIL_CYCLES      = 60;
  localparam int          RANDOM_ITEMS     = 1700;
  localparam int          NUM_REGS         = 8;
  localparam int          MAX_IDX          = (1 << CFG_IDX_W) - 1;
  localparam logic [DUR_W-1:0] DEFAULT_DURATION = 27'd1000000;
  localparam longint unsigned US_PER_S     = 64'd1_000_000;
  localparam longint unsigned US2_PER_S2   = 64'd1_000_000_000_000;
  localparam longint      MIN_WORD         = -64'sd2147483648;
  localparam longint      MAX_WORD         = 64'sd2147483647;

  // One sample of the trajectory; entry 0 of each vector is the x axis.
  typedef struct packed {
    logic [AXES-1:0][DATA_W-1:0] pos;
    logic [AXES-1:0][DATA_W-1:0] vel;
    logic [AXES-1:0][DATA_W-1:0] acc;
  } traj_point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [TIME_W-1:0]    sample_time_i;
  logic                 result_valid_o;
  logic [DATA_W-1:0]    pos_x_o, pos_y_o, pos_z_o;
  logic [DATA_W-1:0]    vel_x_o, vel_y_o, vel_z_o;
  logic [DATA_W-1:0]    acc_x_o, acc_y_o, acc_z_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;

  // Shadow copy of the move registers, updated on each accepted write.
  logic [TIME_W-1:0]        move_start_time;
  logic [DUR_W-1:0]         move_duration;
  logic signed [DATA_W-1:0] from_pt [AXES];
  logic signed [DATA_W-1:0] to_pt [AXES];

  traj_point_t pending_points [$];
  string       axis_name [AXES] = '{"x", "y", "z"};
  int          error_count    = 0;
  int          samples_sent   = 0;
  int          points_checked = 0;
  int          writes_done    = 0;
  int          settings_seen  = 0;
  int          cycle_count    = 0;
  bit          burst_mode     = 1'b0;

  bang_bang_trajectory_generator_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_time_i  (sample_time_i),
    .result_valid_o (result_valid_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .vel_x_o        (vel_x_o),
    .vel_y_o        (vel_y_o),
    .vel_z_o        (vel_z_o),
    .acc_x_o        (acc_x_o),
    .acc_y_o        (acc_y_o),
    .acc_z_o        (acc_z_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Signed magnitude to a saturated 32-bit word.
  function automatic logic [DATA_W-1:0] saturate_mag(input bit neg, input logic [127:0] m);
    if (neg) begin
      return (m >= 128'h8000_0000) ? 32'h8000_0000 : 32'h0 - m[DATA_W-1:0];
    end
    return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] clamp_word(input longint v);
    if (v < MIN_WORD) begin
      return 32'h8000_0000;
    end
    if (v > MAX_WORD) begin
      return 32'h7FFF_FFFF;
    end
    return v[DATA_W-1:0];
  endfunction

  // Expected position, velocity and acceleration at tick t for the current move.
  function automatic traj_point_t trajectory_at(input logic [TIME_W-1:0] t);
    traj_point_t       p;
    longint unsigned   tt, st, span, dt, u, mag;
    longint            diff, off;
    logic [127:0]      den, q;
    bit                neg, first_half;
    tt   = t;
    st   = move_start_time;
    span = (move_duration == '0) ? 64'd1 : 64'(move_duration);
    den  = 128'(span) * 128'(span);
    for (int k = 0; k < AXES; k++) begin
      diff = longint'(to_pt[k]) - longint'(from_pt[k]);
      neg  = diff < 0;
      mag  = neg ? 64'(-diff) : 64'(diff);
      p.vel[k] = '0;
      p.acc[k] = '0;
      if (tt < st) begin
        p.pos[k] = from_pt[k];
      end else if (tt > st + span) begin
        p.pos[k] = to_pt[k];
      end else begin
        // The midpoint and the end tick both belong to the braking half.
        dt         = tt - st;
        first_half = (2 * dt) < span;
        u          = first_half ? dt : span - dt;
        q          = (128'(mag) * 128'(2) * 128'(u) * 128'(u)) / den;
        off        = longint'(q[63:0]);
        if (neg) begin
          off = -off;
        end
        p.pos[k] = first_half ? clamp_word(longint'(from_pt[k]) + off)
                              : clamp_word(longint'(to_pt[k]) - off);
        if (mag != 0) begin
          p.vel[k] = saturate_mag(neg,
              (128'(mag) * 128'(4) * 128'(u) * 128'(US_PER_S)) / den);
          p.acc[k] = saturate_mag(first_half ? neg : !neg,
              (128'(mag) * 128'(4) * 128'(US2_PER_S2)) / den);
        end
      end
    end
    return p;
  endfunction

  function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      error_count++;
    end
  endfunction

  // Each result strobe is compared against the oldest outstanding sample.
  always @(posedge clk_i) begin : result_check
    traj_point_t got;
    traj_point_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got.pos = {pos_z_o, pos_y_o, pos_x_o};
      got.vel = {vel_z_o, vel_y_o, vel_x_o};
      got.acc = {acc_z_o, acc_y_o, acc_x_o};
      points_checked++;
      if (pending_points.size() == 0) begin
        $error("result strobe with no sample outstanding");
        error_count++;
      end else begin
        want = pending_points.pop_front();
        for (int k = 0; k < AXES; k++) begin
          compare_field({"pos_", axis_name[k]}, want.pos[k], got.pos[k]);
          compare_field({"vel_", axis_name[k]}, want.vel[k], got.vel[k]);
          compare_field({"acc_", axis_name[k]}, want.acc[k], got.acc[k]);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // Durations are mostly short so that the move window is hit often.
  function automatic logic [DATA_W-1:0] pick_duration();
    logic [DUR_W-1:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = DUR_W'($urandom_range(1, 64));
      4, 5, 6:    d = DUR_W'($urandom_range(65, 100000));
      7:          d = DUR_W'($urandom_range(0, 3));
      8:          d = $urandom_range(0, 1) ? 27'd100000000 : {DUR_W{1'b1}};
      default:    d = DUR_W'($urandom);
    endcase
    // Bits above the register width carry junk and must be dropped.
    return {5'($urandom), d};
  endfunction

  function automatic logic [DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
    case (idx)
      REG_START_TIME: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
          default: return $urandom;
        endcase
      end
      REG_DURATION: return pick_duration();
      default: return pick_coord();
    endcase
  endfunction

  // Sample ticks cluster inside and at the edges of the move window.
  function automatic logic [TIME_W-1:0] pick_sample_time();
    longint unsigned st, span, v;
    st   = move_start_time;
    span = (move_duration == '0) ? 64'd1 : 64'(move_duration);
    case ($urandom_range(0, 9))
      0: v = st + span / 2 + $urandom_range(0, 2) - 1;
      1: begin
        case ($urandom_range(0, 3))
          0: v = st - 1;
          1: v = st;
          2: v = st + span;
          default: v = st + span + 1;
        endcase
      end
      2, 3: v = $urandom;
      default: v = st + $urandom_range(0, 32'(span));
    endcase
    return v[TIME_W-1:0];
  endfunction

  // One sample transfer; start stays high when the next sample follows at once.
  task automatic send_sample(input logic [TIME_W-1:0] t);
    int gap;
    start         <= 1'b1;
    sample_time_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_points = {pending_points, trajectory_at(t)};
    samples_sent++;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every outstanding point has been checked.
  task automatic settle();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register transfer; valid is left high for a following write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_START_TIME: move_start_time = data;
      REG_DURATION:   move_duration = data[DUR_W-1:0];
      REG_START_X:    from_pt[0] = data;
      REG_START_Y:    from_pt[1] = data;
      REG_START_Z:    from_pt[2] = data;
      REG_END_X:      to_pt[0] = data;
      REG_END_Y:      to_pt[1] = data;
      REG_END_Z:      to_pt[2] = data;
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic cfg_idle();
    cfg_valid_i <= 1'b0;
    settings_seen++;
  endtask

  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(32'(DEFAULT_DURATION));
    send_sample(32'hFFFF_FFFF);
  endtask

  // A plain move: before, start, both halves, exact midpoint, exact end, after.
  task automatic test_move_phases();
    settle();
    cfg_write(REG_START_TIME, 32'd1000);
    cfg_write(REG_DURATION, 32'd2000);
    cfg_write(REG_START_X, 32'hFFFA_8000);
    cfg_write(REG_START_Y, '0);
    cfg_write(REG_START_Z, 32'h7FFF_FFFF);
    cfg_write(REG_END_X, 32'h0064_0000);
    cfg_write(REG_END_Y, 32'h8000_0000);
    cfg_write(REG_END_Z, 32'h7FFF_FFFF);
    cfg_idle();
    send_sample(32'd0);
    send_sample(32'd999);
    send_sample(32'd1000);
    send_sample(32'd1999);
    send_sample(32'd2000);
    send_sample(32'd2999);
    send_sample(32'd3000);
    send_sample(32'd3001);
  endtask

  // Full-scale travel with a window that runs past the top of the tick range.
  task automatic test_extreme_span();
    settle();
    cfg_write(REG_START_TIME, 32'hFFFF_FFF0);
    cfg_write(REG_DURATION, 32'hFFFF_FFFF);
    cfg_write(REG_START_X, 32'h8000_0000);
    cfg_write(REG_END_X, 32'h7FFF_FFFF);
    cfg_write(REG_START_Y, 32'h7FFF_FFFF);
    cfg_write(REG_END_Y, 32'h8000_0000);
    cfg_write(REG_START_Z, '0);
    cfg_write(REG_END_Z, '0);
    cfg_idle();
    send_sample(32'hFFFF_FFEF);
    send_sample(32'hFFFF_FFF0);
    send_sample(32'hFFFF_FFFF);
  endtask

  // One-tick moves saturate velocity and acceleration; a zero duration acts as one.
  task automatic test_short_durations();
    settle();
    cfg_write(REG_START_TIME, '0);
    cfg_write(REG_DURATION, 32'd1);
    cfg_idle();
    send_sample(32'd0);
    send_sample(32'd1);
    send_sample(32'd2);
    settle();
    cfg_write(REG_DURATION, 32'hF800_0000);
    cfg_idle();
    send_sample(32'd0);
    send_sample(32'd1);
    settle();
    cfg_write(REG_DURATION, 32'd2);
    cfg_idle();
    send_sample(32'd1);
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_ignored_index();
    settle();
    cfg_write(CFG_IDX_W'(NUM_REGS), $urandom);
    cfg_write(CFG_IDX_W'(MAX_IDX), $urandom);
    cfg_idle();
    send_sample(32'd1);
  endtask

  // Random moves, each followed by a burst of samples around its window.
  task automatic test_random_moves();
    int        sent;
    int        n;
    bbtg_reg_e r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      r = r.first();
      repeat (r.num()) begin
        if ($urandom_range(0, 3) != 0) begin
          cfg_write(r, pick_reg_value(r));
        end
        r = r.next();
      end
      if ($urandom_range(0, 7) == 0) begin
        cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, MAX_IDX)), $urandom);
      end
      cfg_idle();
      burst_mode = ($urandom_range(0, 4) == 0);
      n = $urandom_range(20, 60);
      repeat (n) begin
        // Now and then the sender holds off until the pipeline has drained.
        if ($urandom_range(0, 49) == 0) begin
          settle();
        end
        send_sample(pick_sample_time());
      end
      sent += n;
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    sample_time_i   <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    move_start_time = '0;
    move_duration   = DEFAULT_DURATION;
    for (int k = 0; k < AXES; k++) begin
      from_pt[k] = '0;
      to_pt[k]   = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_move_phases();
    test_extreme_span();
    test_short_durations();
    test_ignored_index();
    test_random_moves();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples across %0d register settings using %0d register writes.",
             samples_sent, settings_seen, writes_done);
    $display("Checked %0d points before, inside, at midpoint and end, and after each move.",
             points_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bbtg_pkg.sv
sv/bbtg_div.sv
sv/bang_bang_trajectory_generator_core.sv
dv/tb_top.sv
